// ----- src/qslerp_pkg.sv -----
package qslerp_pkg;

    localparam int FRAC_BITS      = 14;
    localparam int ANG_FRAC       = 30;
    localparam int ANGLE_ITER_DEF = 16;
    localparam int COMP_W         = 16;
    localparam int T_W            = 15;
    localparam int ANG_W          = 34;
    localparam int WGT_W          = 17;
    localparam int CSQ_W          = 2 * (FRAC_BITS + 1);
    localparam int RAD_SHIFT      = 2 * (ANG_FRAC - FRAC_BITS);
    localparam int SQRT_IN_W      = CSQ_W - 1 + RAD_SHIFT;
    localparam int SQRT_ACC_W     = SQRT_IN_W + 2;
    localparam int SQRT_OUT_W     = 31;
    localparam int SQRT_STAGES    = 32;
    localparam int DIV_QBITS      = 16;
    localparam int DIV_STAGES     = DIV_QBITS + 1;
    localparam int DIV_W          = ANG_W + FRAC_BITS + 3;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic [T_W-1:0]          NEAR_RESET      = 15'd2;

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        t_comp [3:0]    a;
        t_comp [3:0]    b;
        logic [T_W-1:0] t;
        logic           neg;
        logic           in_rng;
    } t_side;

    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            5'd24:   v = 34'sd63;
            5'd25:   v = 34'sd31;
            5'd26:   v = 34'sd15;
            5'd27:   v = 34'sd8;
            5'd28:   v = 34'sd4;
            5'd29:   v = 34'sd2;
            5'd30:   v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/qslerp_delay.sv -----
module qslerp_delay #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int k = 1; k < D; k++) begin
                r_sh[k] <= r_sh[k-1];
            end
        end
    end

    assign o_q = r_sh[D-1];

endmodule

// ----- src/qslerp_sqrt.sv -----
module qslerp_sqrt import qslerp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [SQRT_IN_W-1:0]  i_rad,
    output logic [SQRT_OUT_W-1:0] o_root
);

    logic [SQRT_ACC_W-1:0] r_rem [SQRT_STAGES];
    logic [SQRT_ACC_W-1:0] r_res [SQRT_STAGES];

    // one result bit per stage, trial bit walks down two places each time
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stg
        localparam logic [SQRT_ACC_W-1:0] BIT = SQRT_ACC_W'(1) << (62 - 2 * k);
        logic [SQRT_ACC_W-1:0] rem_in;
        logic [SQRT_ACC_W-1:0] res_in;
        logic [SQRT_ACC_W-1:0] trial;

        if (k == 0) begin : g_first
            assign rem_in = SQRT_ACC_W'(i_rad);
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BIT;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[k] <= rem_in - trial;
                    r_res[k] <= (res_in >> 1) + BIT;
                end else begin
                    r_rem[k] <= rem_in;
                    r_res[k] <= res_in >> 1;
                end
            end
        end
    end

    assign o_root = r_res[SQRT_STAGES-1][SQRT_OUT_W-1:0];

endmodule

// ----- src/qslerp_acos.sv -----
module qslerp_acos import qslerp_pkg::*; #(
    parameter int ITER = ANGLE_ITER_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_x,
    input  logic signed [ANG_W-1:0] i_y,
    output logic signed [ANG_W-1:0] o_theta
);

    logic signed [ANG_W-1:0] r_x [ITER];
    logic signed [ANG_W-1:0] r_y [ITER];
    logic signed [ANG_W-1:0] r_z [ITER];

    // vectoring: drive y to zero, accumulate the angle in z
    for (genvar k = 0; k < ITER; k++) begin : g_stg
        logic signed [ANG_W-1:0] x_in, y_in, z_in;

        if (k == 0) begin : g_first
            assign x_in = i_x;
            assign y_in = i_y;
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (y_in >= 0) begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + atan_q30(5'(k));
                end else begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - atan_q30(5'(k));
                end
            end
        end
    end

    assign o_theta = r_z[ITER-1];

endmodule

// ----- src/qslerp_sin.sv -----
module qslerp_sin import qslerp_pkg::*; #(
    parameter int ITER = ANGLE_ITER_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_ang,
    output logic signed [ANG_W-1:0] o_sin
);

    logic signed [ANG_W-1:0] r_x [ITER];
    logic signed [ANG_W-1:0] r_y [ITER];
    logic signed [ANG_W-1:0] r_z [ITER];

    // rotation from (1/gain, 0): the final y is the sine
    for (genvar k = 0; k < ITER; k++) begin : g_stg
        logic signed [ANG_W-1:0] x_in, y_in, z_in;

        if (k == 0) begin : g_first
            assign x_in = CORDIC_GAIN_INV;
            assign y_in = '0;
            assign z_in = i_ang;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in >= 0) begin
                    r_x[k] <= x_in - (y_in >>> k);
                    r_y[k] <= y_in + (x_in >>> k);
                    r_z[k] <= z_in - atan_q30(5'(k));
                end else begin
                    r_x[k] <= x_in + (y_in >>> k);
                    r_y[k] <= y_in - (x_in >>> k);
                    r_z[k] <= z_in + atan_q30(5'(k));
                end
            end
        end
    end

    assign o_sin = r_y[ITER-1];

endmodule

// ----- src/qslerp_div.sv -----
module qslerp_div import qslerp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [ANG_W-1:0] i_num,
    input  logic signed [ANG_W-1:0] i_den,
    output logic signed [WGT_W-1:0] o_wgt,
    output logic                    o_ok
);

    localparam logic [WGT_W-1:0] WMAX = WGT_W'(1) << (FRAC_BITS + 1);

    logic [DIV_W-1:0]     r_den0, r_rem0;
    logic                 r_neg0, r_ok0, r_ovf0;
    logic [DIV_W-1:0]     r_den [DIV_QBITS];
    logic [DIV_W-1:0]     r_rem [DIV_QBITS];
    logic [DIV_QBITS-1:0] r_q   [DIV_QBITS];
    logic                 r_neg [DIV_QBITS];
    logic                 r_ok  [DIV_QBITS];
    logic                 r_ovf [DIV_QBITS];

    logic                 num_neg, den_ok;
    logic [ANG_W:0]       num_mag;
    logic [DIV_W-1:0]     num_sh, den_use;
    logic [WGT_W-1:0]     mag;
    logic                 sat;

    // setup: magnitude of the numerator, guard a non-positive divisor
    always_comb begin
        num_neg = i_num < 0;
        num_mag = num_neg ? (ANG_W+1)'(-$signed({i_num[ANG_W-1], i_num}))
                          : (ANG_W+1)'({1'b0, i_num});
        num_sh  = DIV_W'(num_mag) << FRAC_BITS;
        den_ok  = i_den > 0;
        den_use = den_ok ? DIV_W'(i_den) : DIV_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0 <= num_sh;
            r_den0 <= den_use;
            r_neg0 <= num_neg;
            r_ok0  <= den_ok;
            r_ovf0 <= num_sh >= (den_use << DIV_QBITS);
        end
    end

    // restoring division, one quotient bit per stage from the top
    for (genvar i = 0; i < DIV_QBITS; i++) begin : g_stg
        localparam int J = DIV_QBITS - 1 - i;
        logic [DIV_W-1:0]     rem_in, den_in, den_sh;
        logic [DIV_QBITS-1:0] q_in;
        logic                 neg_in, ok_in, ovf_in;

        if (i == 0) begin : g_first
            assign rem_in = r_rem0;
            assign den_in = r_den0;
            assign q_in   = '0;
            assign neg_in = r_neg0;
            assign ok_in  = r_ok0;
            assign ovf_in = r_ovf0;
        end else begin : g_next
            assign rem_in = r_rem[i-1];
            assign den_in = r_den[i-1];
            assign q_in   = r_q[i-1];
            assign neg_in = r_neg[i-1];
            assign ok_in  = r_ok[i-1];
            assign ovf_in = r_ovf[i-1];
        end

        assign den_sh = den_in << J;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[i] <= den_in;
                r_neg[i] <= neg_in;
                r_ok[i]  <= ok_in;
                r_ovf[i] <= ovf_in;
                if (rem_in >= den_sh) begin
                    r_rem[i] <= rem_in - den_sh;
                    r_q[i]   <= q_in | (DIV_QBITS'(1) << J);
                end else begin
                    r_rem[i] <= rem_in;
                    r_q[i]   <= q_in;
                end
            end
        end
    end

    // saturate the magnitude to two, then restore the sign
    always_comb begin
        sat   = r_ovf[DIV_QBITS-1] || ({1'b0, r_q[DIV_QBITS-1]} > WMAX);
        mag   = sat ? WMAX : {1'b0, r_q[DIV_QBITS-1]};
        o_wgt = r_neg[DIV_QBITS-1] ? -$signed(mag) : $signed(mag);
        o_ok  = r_ok[DIV_QBITS-1];
    end

endmodule

// ----- src/quaternion_slerp_core.sv -----
// The 32-stage square root, the two CORDIC chains and the 17-stage dividers set
// the pipeline depth from an accepted input transaction to m_axis_tvalid.
// Throughput: one transaction per cycle while the skid slot is empty; every stage
// is its own register.
// Reset (i_rst_n low at a clock edge) empties the pipeline and the output
// skid buffer and restores near_threshold to 2; data registers are not reset.
module quaternion_slerp_core import qslerp_pkg::*; #(
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), t_frac (15), 1 pad bit
    input  logic [143:0]   s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // out_x, out_y, out_z, out_w (16 each)
    output logic [63:0]    m_axis_tdata,
    input  logic           i_cfg_we,
    input  logic [T_W-1:0] i_cfg_wdata
);

    localparam int ITER        = ANGLE_ITERATIONS;
    localparam int ONE         = 1 << FRAC_BITS;
    // stage numbers: stage k is the k-th pipeline register after acceptance
    localparam int ST_ACOS_OUT = 3 + SQRT_STAGES + ITER;
    localparam int ST_SIN_OUT  = ST_ACOS_OUT + 2 + ITER;
    localparam int ST_DIV_OUT  = ST_SIN_OUT + DIV_STAGES;
    localparam int LAT         = ST_DIV_OUT + 3;

    // ---------------- configuration ----------------
    logic [T_W-1:0] r_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RESET;
        end else if (i_cfg_we) begin
            r_near <= i_cfg_wdata;
        end
    end

    // ---------------- flow control ----------------
    // The pipeline advances whenever the skid slot is free, so new transactions
    // keep entering while a finished result waits in the output register.
    logic           en;
    logic [LAT:1]   r_vld;
    logic           r_out_vld, r_skid_vld;
    logic [63:0]    r_out_data, r_skid_data, pipe_data;
    logic           take;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;
    assign take          = r_out_vld && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-1:1], s_axis_tvalid};
        end
    end

    // ---------------- stage 1: dot-product lanes ----------------
    t_comp          in_a [4];
    t_comp          in_b [4];
    logic [T_W-1:0] in_t;
    logic signed [2*COMP_W-1:0] r_prod [4];
    t_comp          r_a1 [4];
    t_comp          r_b1 [4];
    logic [T_W-1:0] r_t1;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_a[i] = s_axis_tdata[COMP_W*i +: COMP_W];
            in_b[i] = s_axis_tdata[COMP_W*(4+i) +: COMP_W];
        end
        in_t = s_axis_tdata[8*COMP_W +: T_W];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= in_a[i] * in_b[i];
                r_a1[i]   <= in_a[i];
                r_b1[i]   <= in_b[i];
            end
            // clamp the blend factor to one
            r_t1 <= (in_t > T_W'(ONE)) ? T_W'(ONE) : in_t;
        end
    end

    // ---------------- stage 2: merge lanes into |cos| ----------------
    logic signed [2*COMP_W+1:0]      dot;
    logic signed [2*COMP_W-FRAC_BITS+1:0] cfl;
    logic [2*COMP_W-FRAC_BITS+1:0]   cmag;
    logic [T_W-1:0]                  cclip;
    logic                            cneg;
    t_side                           side2;
    t_side                           r_side;
    logic [T_W-1:0]                  r_c;

    always_comb begin
        dot = '0;
        for (int i = 0; i < 4; i++) begin
            dot = dot + (2*COMP_W+2)'(r_prod[i]);
        end
        // floor shift back to Q14, then fold the sign and clip to one
        cfl   = dot[2*COMP_W+1:FRAC_BITS];
        cneg  = cfl < 0;
        cmag  = cneg ? $unsigned(-cfl) : $unsigned(cfl);
        cclip = (cmag > (2*COMP_W-FRAC_BITS+2)'(ONE)) ? T_W'(ONE) : cmag[T_W-1:0];
        for (int i = 0; i < 4; i++) begin
            side2.a[i] = r_a1[i];
            side2.b[i] = r_b1[i];
        end
        side2.t      = r_t1;
        side2.neg    = cneg;
        side2.in_rng = ({2'b00, cclip} + {2'b00, r_near}) <= (T_W+2)'(ONE);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side <= side2;
            r_c    <= cclip;
        end
    end

    // ---------------- stage 3: cos squared ----------------
    logic [CSQ_W-1:0]     r_csq;
    logic [T_W-1:0]       r_c3;
    logic [CSQ_W-2:0]     sq_m;
    logic [SQRT_IN_W-1:0] rad;
    logic [SQRT_OUT_W-1:0] sin_root;
    logic [T_W-1:0]       c_d;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_csq <= r_c * r_c;
            r_c3  <= r_c;
        end
    end

    // sin(theta) = sqrt(1 - cos^2), formed in Q30
    assign sq_m = (CSQ_W-1)'((CSQ_W)'(1) << (2*FRAC_BITS)) - (CSQ_W-1)'(r_csq);
    assign rad  = {sq_m, RAD_SHIFT'(0)};

    qslerp_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (sin_root)
    );

    qslerp_delay #(.W(T_W), .D(SQRT_STAGES)) u_dly_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_c3),
        .o_q   (c_d)
    );

    // ---------------- acos by vectoring ----------------
    logic signed [ANG_W-1:0] acos_x, acos_y, theta;

    assign acos_x = $signed(ANG_W'({c_d, (ANG_FRAC-FRAC_BITS)'(0)}));
    assign acos_y = $signed(ANG_W'(sin_root));

    qslerp_acos #(.ITER(ITER)) u_acos (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_x     (acos_x),
        .i_y     (acos_y),
        .o_theta (theta)
    );

    // ---------------- t*theta and (1-t)*theta ----------------
    logic [T_W-1:0]                    t_d;
    logic signed [ANG_W+T_W:0]         r_m1_prod;
    logic signed [ANG_W-1:0]           r_m1_theta;
    logic signed [ANG_W-1:0]           r_m2_theta, r_m2_tt, r_m2_rest;
    logic signed [ANG_W-1:0]           tt;

    qslerp_delay #(.W(T_W), .D(ST_ACOS_OUT - 2)) u_dly_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_side.t),
        .o_q   (t_d)
    );

    assign tt = ANG_W'(r_m1_prod >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_prod  <= theta * $signed({1'b0, t_d});
            r_m1_theta <= theta;
            r_m2_theta <= r_m1_theta;
            r_m2_tt    <= tt;
            r_m2_rest  <= r_m1_theta - tt;
        end
    end

    // ---------------- three sine lanes ----------------
    logic signed [ANG_W-1:0] s_th, s_t, s_rest;

    qslerp_sin #(.ITER(ITER)) u_sin_th (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_m2_theta),
        .o_sin (s_th)
    );

    qslerp_sin #(.ITER(ITER)) u_sin_t (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_m2_tt),
        .o_sin (s_t)
    );

    qslerp_sin #(.ITER(ITER)) u_sin_rest (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ang (r_m2_rest),
        .o_sin (s_rest)
    );

    // ---------------- weight dividers ----------------
    logic signed [WGT_W-1:0] dw1, dw2;
    logic                    ok1, ok2;

    qslerp_div u_div_w1 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (s_rest),
        .i_den (s_th),
        .o_wgt (dw1),
        .o_ok  (ok1)
    );

    qslerp_div u_div_w2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (s_t),
        .i_den (s_th),
        .o_wgt (dw2),
        .o_ok  (ok2)
    );

    // ---------------- weight select ----------------
    t_side                   side_d;
    logic                    use_slerp;
    logic signed [WGT_W-1:0] w1, w2, w2s;
    logic signed [WGT_W-1:0] r_w1, r_w2;
    t_comp                   r_aw [4];
    t_comp                   r_bw [4];

    qslerp_delay #(.W($bits(t_side)), .D(ST_DIV_OUT - 2)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_side),
        .o_q   (side_d)
    );

    // fall back to linear weights near cos = 1 or when sin(theta) is not positive
    always_comb begin
        use_slerp = side_d.in_rng && ok1 && ok2;
        w1  = use_slerp ? dw1 : $signed(WGT_W'(ONE) - WGT_W'(side_d.t));
        w2  = use_slerp ? dw2 : $signed(WGT_W'(side_d.t));
        w2s = side_d.neg ? -w2 : w2;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w1 <= w1;
            r_w2 <= w2s;
            for (int i = 0; i < 4; i++) begin
                r_aw[i] <= side_d.a[i];
                r_bw[i] <= side_d.b[i];
            end
        end
    end

    // ---------------- blend lanes ----------------
    logic signed [COMP_W+WGT_W-1:0] r_pa [4];
    logic signed [COMP_W+WGT_W-1:0] r_pb [4];
    logic signed [COMP_W+WGT_W:0]   vsum [4];
    logic signed [COMP_W+WGT_W-FRAC_BITS:0] vsh [4];
    t_comp                          vclip [4];
    t_comp                          r_res [4];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_pa[i] <= r_aw[i] * r_w1;
                r_pb[i] <= r_bw[i] * r_w2;
            end
        end
    end

    // round half up, floor shift, saturate to [-1, +1]
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            vsum[i] = (COMP_W+WGT_W+1)'(r_pa[i]) + (COMP_W+WGT_W+1)'(r_pb[i])
                      + (COMP_W+WGT_W+1)'(1 << (FRAC_BITS - 1));
            vsh[i]  = vsum[i][COMP_W+WGT_W:FRAC_BITS];
            if (vsh[i] > (COMP_W+WGT_W-FRAC_BITS+1)'(ONE)) begin
                vclip[i] = COMP_W'(ONE);
            end else if (vsh[i] < -$signed((COMP_W+WGT_W-FRAC_BITS+1)'(ONE))) begin
                vclip[i] = -$signed(COMP_W'(ONE));
            end else begin
                vclip[i] = vsh[i][COMP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_res[i] <= vclip[i];
            end
        end
    end

    assign pipe_data = {r_res[3], r_res[2], r_res[1], r_res[0]};

    // ---------------- output register and skid slot ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // pipeline is held; drain the skid slot when the sink takes
            if (take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAT]) begin
            if (!r_out_vld || take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_data <= r_skid_data;
            end
        end else if (r_vld[LAT]) begin
            if (!r_out_vld || take) begin
                r_out_data <= pipe_data;
            end else begin
                r_skid_data <= pipe_data;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule
